>>> rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg - shared types and constants
// Result word layout, node bound, command codes and the cap on words per run.
// ----------------------------------------------------------------------------
package scc_pkg;

    // node ids travel as 6-bit fields on both channels
    localparam int MAX_NODES  = 64;
    localparam int RESULT_CAP = 64;
    localparam int RES_CNT_W  = 7;

    // command kinds on s_tuser[0]
    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_RUN      = 1'b1;

    typedef struct packed {
        logic       run_last;
        logic       comp_last;
        logic       overflow;
        logic [6:0] comp_total;
        logic [5:0] comp_index;
        logic [5:0] node_id;
    } scc_res_t;

endpackage

>>> rtl/scc_ram.sv
// ----------------------------------------------------------------------------
// scc_ram - simple dual-port RAM
// One write port, one read port with enable and registered data.
// ----------------------------------------------------------------------------
module scc_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic                 re,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/scc_out_buf.sv
// ----------------------------------------------------------------------------
// scc_out_buf - result holding stage
// Holds the newest word back so its end marks can still be set, plus the
// output register facing the stream.
// ----------------------------------------------------------------------------
module scc_out_buf import scc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  scc_res_t push_res,
    input  logic     close_comp,
    input  logic     flush,
    output logic     can_take,
    output logic     m_tvalid,
    input  logic     m_tready,
    output scc_res_t m_res
);

    logic     pend_v_reg, pend_v_next;
    scc_res_t pend_reg, pend_next;
    logic     out_v_reg, out_v_next;
    scc_res_t out_reg, out_next;
    logic     out_free;

    assign out_free = !out_v_reg || m_tready;
    assign can_take = !pend_v_reg || out_free;
    assign m_tvalid = out_v_reg;
    assign m_res    = out_reg;

    always_comb begin
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        out_v_next  = out_v_reg && !m_tready;
        out_next    = out_reg;
        if (push) begin
            if (pend_v_reg) begin
                out_v_next = 1'b1;
                out_next   = pend_reg;
            end
            pend_v_next = 1'b1;
            pend_next   = push_res;
        end else if (flush) begin
            if (pend_v_reg) begin
                out_v_next        = 1'b1;
                out_next          = pend_reg;
                out_next.run_last = 1'b1;
            end
            pend_v_next = 1'b0;
        end else if (close_comp && pend_v_reg) begin
            pend_next.comp_last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

>>> rtl/strongly_connected_components_unit.sv
// ----------------------------------------------------------------------------
// strongly_connected_components_unit - Kosaraju SCC engine
// Edge store plus a two-pass depth-first sequencer over one edge RAM port.
// ----------------------------------------------------------------------------
// Usage:
//  s_ channel: one word per command. s_tuser[0] = 0 appends an edge
//    (tdata: edge_from, edge_to, undirected), 1 starts a component search.
//  m_ channel: one word per node reached by the second pass, grouped by
//    component; tlast marks the last word of a run, tuser the last of a
//    component. Up to 64 words per run.
//  cfg_we/cfg_wdata: node_count, written while idle (reset value 64).
//  Add-edge: an undirected edge also writes the reverse word. A run is
//    dominated by the edge RAM read loop, each read going through a read
//    and a check state; the second pass makes a full edge sweep for every
//    push and pop.
//  s_tready is low for the whole run.
//  Reset clears the edge count, overflow flag and output stage; no sweep.
//  A stalled receiver holds up the sequencer only when both the output
//  register and the held-back word are full.
// ----------------------------------------------------------------------------
module strongly_connected_components_unit import scc_pkg::*; #(
    parameter int MAX_EDGES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // edge_from[5:0], edge_to[11:6], undirected[12], zero
    input  logic [0:0]  s_tuser,   // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // node_id[5:0], component_index[11:6],
                                   // component_total[18:12], edge_overflow[19], zero
    output logic [0:0]  m_tuser,   // component_last[0]
    output logic        m_tlast,   // run_last
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);

    localparam int NW  = $clog2(MAX_NODES);     // node id
    localparam int NAW = $clog2(MAX_NODES);     // stack address
    localparam int CW  = $clog2(MAX_NODES + 1); // node counts
    localparam int AW  = $clog2(MAX_EDGES);     // edge address
    localparam int EW  = $clog2(MAX_EDGES + 1); // edge counts
    localparam int WW  = NW + EW;               // walk stack entry

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_ADD2     = 4'd1;
    localparam logic [3:0] ST_P1_START = 4'd2;
    localparam logic [3:0] ST_P1_RD    = 4'd3;
    localparam logic [3:0] ST_P1_CHK   = 4'd4;
    localparam logic [3:0] ST_P1_POP   = 4'd5;
    localparam logic [3:0] ST_P2_NEXT  = 4'd6;
    localparam logic [3:0] ST_P2_SEED  = 4'd7;
    localparam logic [3:0] ST_P2_RD    = 4'd8;
    localparam logic [3:0] ST_P2_CHK   = 4'd9;
    localparam logic [3:0] ST_P2_DEC   = 4'd10;
    localparam logic [3:0] ST_P2_POP   = 4'd11;
    localparam logic [3:0] ST_FINISH   = 4'd12;

    logic [3:0]           state_reg, state_next;
    logic [6:0]           node_count_reg;
    logic [EW-1:0]        edge_total_reg, edge_total_next;
    logic                 ovf_reg, ovf_next;
    logic [MAX_NODES-1:0] vis1_reg, vis1_next, vis2_reg, vis2_next;
    logic [CW-1:0]        starts_reg, starts_next;
    logic [CW-1:0]        start_reg, start_next;
    logic [NW-1:0]        cur_reg, cur_next;
    logic [EW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        sp_reg, sp_next;
    logic [CW-1:0]        fin_top_reg, fin_top_next;
    logic [NW-1:0]        best_reg, best_next;
    logic                 best_v_reg, best_v_next;
    logic [CW-1:0]        comp_reg, comp_next;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic [NW-1:0]        add_a_reg, add_a_next, add_b_reg, add_b_next;

    // RAM ports
    logic          e_we, e_re;
    logic [2*NW-1:0] e_wdata, e_rdata;
    logic          w_we, w_re;
    logic [WW-1:0] w_wdata, w_rdata;
    logic          f_we, f_re;
    logic [NW-1:0] f_wdata, f_rdata;
    logic [CW-1:0] sp_m1, fin_m1;

    // output stage
    logic     ob_push, ob_close, ob_flush, ob_can;
    scc_res_t ob_res, m_res;

    logic [5:0]    in_from, in_to;
    logic          in_und, in_kind, in_ok;
    logic [NW-1:0] ed_src, ed_dst;
    logic          room;
    logic          emit_ok;

    assign in_from = s_tdata[5:0];
    assign in_to   = s_tdata[11:6];
    assign in_und  = s_tdata[12];
    assign in_kind = s_tuser[0];
    assign in_ok   = (32'(in_from) < MAX_NODES) && (32'(in_to) < MAX_NODES);

    assign ed_src  = e_rdata[NW-1:0];
    assign ed_dst  = e_rdata[2*NW-1:NW];
    assign sp_m1   = sp_reg - CW'(1);
    assign fin_m1  = fin_top_reg - CW'(1);
    assign room    = edge_total_reg != EW'(MAX_EDGES);
    // past the word cap nothing is pushed, so there is nothing to wait for
    assign emit_ok = (res_cnt_reg < RES_CNT_W'(RESULT_CAP)) ? ob_can : 1'b1;

    assign s_tready = state_reg == ST_IDLE;

    always_comb begin
        state_next      = state_reg;
        edge_total_next = edge_total_reg;
        ovf_next        = ovf_reg;
        vis1_next       = vis1_reg;
        vis2_next       = vis2_reg;
        starts_next     = starts_reg;
        start_next      = start_reg;
        cur_next        = cur_reg;
        pos_next        = pos_reg;
        sp_next         = sp_reg;
        fin_top_next    = fin_top_reg;
        best_next       = best_reg;
        best_v_next     = best_v_reg;
        comp_next       = comp_reg;
        res_cnt_next    = res_cnt_reg;
        add_a_next      = add_a_reg;
        add_b_next      = add_b_reg;
        e_we     = 1'b0;
        e_wdata  = {add_a_reg, add_b_reg};
        e_re     = 1'b0;
        w_we     = 1'b0;
        w_wdata  = {pos_reg + EW'(1), cur_reg};
        w_re     = 1'b0;
        f_we     = 1'b0;
        f_wdata  = cur_reg;
        f_re     = 1'b0;
        ob_push  = 1'b0;
        ob_close = 1'b0;
        ob_flush = 1'b0;
        ob_res.run_last   = 1'b0;
        ob_res.comp_last  = 1'b0;
        ob_res.overflow   = ovf_reg;
        ob_res.comp_total = 7'(comp_reg) + 7'd1;
        ob_res.comp_index = 6'(comp_reg);
        ob_res.node_id    = 6'(f_rdata);

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_kind == CMD_RUN) begin
                        vis1_next    = '0;
                        vis2_next    = '0;
                        starts_next  = (32'(node_count_reg) > MAX_NODES) ?
                                       CW'(MAX_NODES) : CW'(node_count_reg);
                        start_next   = '0;
                        fin_top_next = '0;
                        comp_next    = '0;
                        res_cnt_next = '0;
                        state_next   = ST_P1_START;
                    end else begin
                        // word stored as {dst, src}
                        e_wdata    = {NW'(in_to), NW'(in_from)};
                        add_a_next = NW'(in_from);
                        add_b_next = NW'(in_to);
                        if (in_ok) begin
                            if (room) begin
                                e_we            = 1'b1;
                                edge_total_next = edge_total_reg + EW'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                            if (in_und) begin
                                state_next = ST_ADD2;
                            end
                        end
                    end
                end
            end
            ST_ADD2: begin
                // reverse half: add_a is the destination now
                if (room) begin
                    e_we            = 1'b1;
                    edge_total_next = edge_total_reg + EW'(1);
                end else begin
                    ovf_next = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_P1_START: begin
                if (start_reg == starts_reg) begin
                    state_next = ST_P2_NEXT;
                end else if (vis1_reg[start_reg[NW-1:0]]) begin
                    start_next = start_reg + CW'(1);
                end else begin
                    vis1_next[start_reg[NW-1:0]] = 1'b1;
                    cur_next   = start_reg[NW-1:0];
                    pos_next   = '0;
                    sp_next    = '0;
                    state_next = ST_P1_RD;
                end
            end
            ST_P1_RD: begin
                if (pos_reg == edge_total_reg) begin
                    // node finished
                    f_we         = 1'b1;
                    fin_top_next = fin_top_reg + CW'(1);
                    if (sp_reg == '0) begin
                        start_next = start_reg + CW'(1);
                        state_next = ST_P1_START;
                    end else begin
                        w_re       = 1'b1;
                        sp_next    = sp_m1;
                        state_next = ST_P1_POP;
                    end
                end else begin
                    e_re       = 1'b1;
                    state_next = ST_P1_CHK;
                end
            end
            ST_P1_CHK: begin
                if (ed_src == cur_reg && !vis1_reg[ed_dst]) begin
                    vis1_next[ed_dst] = 1'b1;
                    w_we     = 1'b1;
                    sp_next  = sp_reg + CW'(1);
                    cur_next = ed_dst;
                    pos_next = '0;
                end else begin
                    pos_next = pos_reg + EW'(1);
                end
                state_next = ST_P1_RD;
            end
            ST_P1_POP: begin
                cur_next   = w_rdata[NW-1:0];
                pos_next   = w_rdata[WW-1:NW];
                state_next = ST_P1_RD;
            end
            ST_P2_NEXT: begin
                if (fin_top_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    f_re         = 1'b1;
                    fin_top_next = fin_m1;
                    state_next   = ST_P2_SEED;
                end
            end
            ST_P2_SEED: begin
                if (vis2_reg[f_rdata]) begin
                    state_next = ST_P2_NEXT;
                end else if (emit_ok) begin
                    vis2_next[f_rdata] = 1'b1;
                    if (res_cnt_reg < RES_CNT_W'(RESULT_CAP)) begin
                        ob_push      = 1'b1;
                        res_cnt_next = res_cnt_reg + RES_CNT_W'(1);
                    end
                    cur_next    = f_rdata;
                    sp_next     = '0;
                    pos_next    = '0;
                    best_v_next = 1'b0;
                    state_next  = ST_P2_RD;
                end
            end
            ST_P2_RD: begin
                if (pos_reg == edge_total_reg) begin
                    state_next = ST_P2_DEC;
                end else begin
                    e_re       = 1'b1;
                    state_next = ST_P2_CHK;
                end
            end
            ST_P2_CHK: begin
                // smallest unvisited source of an edge into cur
                if (ed_dst == cur_reg && !vis2_reg[ed_src] &&
                    (!best_v_reg || ed_src < best_reg)) begin
                    best_next   = ed_src;
                    best_v_next = 1'b1;
                end
                pos_next   = pos_reg + EW'(1);
                state_next = ST_P2_RD;
            end
            ST_P2_DEC: begin
                ob_res.node_id = 6'(best_reg);
                if (best_v_reg) begin
                    if (emit_ok) begin
                        vis2_next[best_reg] = 1'b1;
                        if (res_cnt_reg < RES_CNT_W'(RESULT_CAP)) begin
                            ob_push      = 1'b1;
                            res_cnt_next = res_cnt_reg + RES_CNT_W'(1);
                        end
                        w_we        = 1'b1;
                        w_wdata     = {EW'(0), cur_reg};
                        sp_next     = sp_reg + CW'(1);
                        cur_next    = best_reg;
                        pos_next    = '0;
                        best_v_next = 1'b0;
                        state_next  = ST_P2_RD;
                    end
                end else if (sp_reg == '0) begin
                    ob_close   = 1'b1;
                    comp_next  = comp_reg + CW'(1);
                    state_next = ST_P2_NEXT;
                end else begin
                    w_re       = 1'b1;
                    sp_next    = sp_m1;
                    state_next = ST_P2_POP;
                end
            end
            ST_P2_POP: begin
                cur_next    = w_rdata[NW-1:0];
                pos_next    = '0;
                best_v_next = 1'b0;
                state_next  = ST_P2_RD;
            end
            ST_FINISH: begin
                if (ob_can) begin
                    ob_flush   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_count_reg <= 7'd64;
            edge_total_reg <= '0;
            ovf_reg        <= 1'b0;
        end else begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            ovf_reg        <= ovf_next;
            if (cfg_we) begin
                node_count_reg <= cfg_wdata;
            end
        end
        vis1_reg    <= vis1_next;
        vis2_reg    <= vis2_next;
        starts_reg  <= starts_next;
        start_reg   <= start_next;
        cur_reg     <= cur_next;
        pos_reg     <= pos_next;
        sp_reg      <= sp_next;
        fin_top_reg <= fin_top_next;
        best_reg    <= best_next;
        best_v_reg  <= best_v_next;
        comp_reg    <= comp_next;
        res_cnt_reg <= res_cnt_next;
        add_a_reg   <= add_a_next;
        add_b_reg   <= add_b_next;
    end

    // edge store: {destination, source}
    scc_ram #(.W(2*NW), .D(MAX_EDGES)) u_edges (
        .aclk  (aclk),
        .we    (e_we),
        .waddr (edge_total_reg[AW-1:0]),
        .wdata (e_wdata),
        .re    (e_re),
        .raddr (pos_reg[AW-1:0]),
        .rdata (e_rdata)
    );

    // walk stack below the current node: {resume position, node}
    scc_ram #(.W(WW), .D(MAX_NODES)) u_walk (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (sp_reg[NAW-1:0]),
        .wdata (w_wdata),
        .re    (w_re),
        .raddr (sp_m1[NAW-1:0]),
        .rdata (w_rdata)
    );

    // finishing order
    scc_ram #(.W(NW), .D(MAX_NODES)) u_finish (
        .aclk  (aclk),
        .we    (f_we),
        .waddr (fin_top_reg[NAW-1:0]),
        .wdata (f_wdata),
        .re    (f_re),
        .raddr (fin_m1[NAW-1:0]),
        .rdata (f_rdata)
    );

    scc_out_buf u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (ob_push),
        .push_res   (ob_res),
        .close_comp (ob_close),
        .flush      (ob_flush),
        .can_take   (ob_can),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_res      (m_res)
    );

    assign m_tdata = {4'd0, m_res.overflow, m_res.comp_total,
                      m_res.comp_index, m_res.node_id};
    assign m_tuser = m_res.comp_last;
    assign m_tlast = m_res.run_last;

    // a run word must start the first pass
    a_run_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == CMD_RUN |=> state_reg == ST_P1_START)
        else $error("run word did not start first pass");

    // overflow is sticky
    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> !$fell(ovf_reg))
        else $error("overflow flag cleared");

    // stacks stay within depth during a run
    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE && state_reg != ST_ADD2 |->
        32'(sp_reg) <= MAX_NODES && 32'(fin_top_reg) <= MAX_NODES)
        else $error("stack pointer beyond depth");

endmodule
